/* hw/rtl/fdbe_pkg.sv */
`default_nettype none
package fdbe_pkg;

	// Default frame geometry
	localparam int ROWS_DEF      = 64;
	localparam int ROW_BYTES_DEF = 16;

	// Field widths
	localparam int ROW_W    = 6;
	localparam int COL_W    = 4;
	localparam int BYTE_W   = 8;
	localparam int BUDGET_W = 6;
	localparam int FC_W     = 11;
	localparam int X_W      = BUDGET_W + 1;
	localparam int Y_W      = FC_W + 1;
	localparam int ACC_W    = FC_W + X_W;

	localparam logic [BUDGET_W-1:0] BUDGET_RST = 6'd63;
	localparam logic [FC_W-1:0]     FC_MAX     = 11'h7FF;
	localparam logic [BYTE_W-1:0]   EOD_BYTE   = 8'hFF;

	// Request codes
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_EOF  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [BYTE_W-1:0] pixel_byte;
	} pix_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
		logic [BYTE_W-1:0] byte_value;
		logic              end_marker;
		logic              last;
	} rec_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_FB_RD,
		ST_FB_EV,
		ST_FB_PUSH,
		ST_P1_TEST,
		ST_P1_RD,
		ST_P1_EV,
		ST_P2_TEST,
		ST_P2_RD,
		ST_P2_EV,
		ST_MARK,
		ST_FLUSH
	} state_t;

	typedef enum logic [2:0] {
		CUR_KEEP,
		CUR_RASTER,
		CUR_HEAD,
		CUR_TAIL,
		CUR_NEXT
	} cur_sel_t;

	typedef struct packed {
		logic     clr;
		cur_sel_t cur_sel;
		logic     latch_byte;
		logic     write_byte;
		logic     remove;
		logic     push;
		logic     adv_raster;
		logic     p1_init;
		logic     p1_step;
		logic     x_inc;
		logic     emit_rec;
		logic     emit_mark;
		logic     flush;
		logic     frame_end;
	} cmd_t;

	typedef struct packed {
		logic changed;
		logic pending;
		logic hit;
		logic p1_more;
		logic p2_more;
		logic room;
		logic can_push;
		logic hold_v;
		logic out_free;
		logic clr_last;
	} stat_t;

endpackage
`default_nettype wire

/* hw/rtl/fdbe_ctrl.sv */
`default_nettype none
module fdbe_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pix_valid,
	input  wire logic          req_type,
	output logic               pix_stall,
	input  wire fdbe_pkg::stat_t stat,
	output fdbe_pkg::cmd_t     cmd
);
	import fdbe_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (pix_valid) begin
					state_d = (req_type == REQ_BYTE) ? ST_FB_RD : ST_P1_TEST;
				end
			end
			ST_FB_RD:   state_d = ST_FB_EV;
			ST_FB_EV:   state_d = stat.changed ? ST_FB_PUSH : ST_IDLE;
			ST_FB_PUSH: state_d = ST_IDLE;
			ST_P1_TEST: state_d = stat.p1_more ? ST_P1_RD : ST_P2_TEST;
			ST_P1_RD:   state_d = ST_P1_EV;
			ST_P1_EV: begin
				if (!stat.hit || stat.can_push) state_d = ST_P1_TEST;
			end
			ST_P2_TEST: state_d = stat.p2_more ? ST_P2_RD : ST_MARK;
			ST_P2_RD:   state_d = ST_P2_EV;
			ST_P2_EV: begin
				if (stat.can_push) state_d = ST_P2_TEST;
			end
			ST_MARK: begin
				if (!stat.room || stat.can_push) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!stat.hold_v || stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLR;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd         = '0;
		cmd.cur_sel = CUR_KEEP;
		pix_stall   = (state_q != ST_IDLE);
		unique case (state_q)
			ST_CLR: cmd.clr = 1'b1;
			ST_IDLE: begin
				if (pix_valid) begin
					if (req_type == REQ_BYTE) begin
						cmd.latch_byte = 1'b1;
						cmd.cur_sel    = CUR_RASTER;
					end else begin
						cmd.p1_init = 1'b1;
						cmd.cur_sel = CUR_HEAD;
					end
				end
			end
			ST_FB_RD: ;
			ST_FB_EV: begin
				if (stat.changed) begin
					cmd.write_byte = 1'b1;
					cmd.remove     = stat.pending;
				end else begin
					cmd.adv_raster = 1'b1;
				end
			end
			ST_FB_PUSH: begin
				cmd.push       = 1'b1;
				cmd.adv_raster = 1'b1;
			end
			ST_P1_TEST: ;
			ST_P1_RD: ;
			ST_P1_EV: begin
				if (!stat.hit || stat.can_push) begin
					cmd.emit_rec = stat.hit;
					cmd.x_inc    = stat.hit;
					cmd.remove   = stat.hit;
					cmd.p1_step  = 1'b1;
					cmd.cur_sel  = CUR_NEXT;
				end
			end
			ST_P2_TEST: begin
				if (stat.p2_more) cmd.cur_sel = CUR_TAIL;
			end
			ST_P2_RD: ;
			ST_P2_EV: begin
				if (stat.can_push) begin
					cmd.emit_rec = 1'b1;
					cmd.x_inc    = 1'b1;
					cmd.remove   = 1'b1;
				end
			end
			ST_MARK: begin
				cmd.emit_mark = stat.room && stat.can_push;
			end
			ST_FLUSH: begin
				if (!stat.hold_v || stat.out_free) begin
					cmd.flush     = stat.hold_v;
					cmd.frame_end = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/fdbe_dp.sv */
`default_nettype none
module fdbe_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fdbe_pkg::cmd_t                  cmd,
	output fdbe_pkg::stat_t                      stat,
	input  wire logic [fdbe_pkg::BYTE_W-1:0]     pix_byte,
	input  wire logic                            cfg_valid,
	input  wire logic [fdbe_pkg::BUDGET_W-1:0]   cfg_data,
	input  wire logic                            rec_stall,
	output logic                                 rec_valid,
	output fdbe_pkg::rec_t                       rec
);
	import fdbe_pkg::*;

	localparam int FRAME = ROWS_DEF * ROW_BYTES_DEF;
	localparam int AW    = (FRAME > 1) ? $clog2(FRAME) : 1;
	localparam int CW    = $clog2(FRAME + 1);

	// Memories and their registered read data
	logic [BYTE_W-1:0] fs_mem [FRAME];
	logic              pf_mem [FRAME];
	logic [AW-1:0]     nl_mem [FRAME];
	logic [AW-1:0]     pl_mem [FRAME];
	logic [BYTE_W-1:0] fs_rd_q;
	logic              pf_rd_q;
	logic [AW-1:0]     nl_rd_q;
	logic [AW-1:0]     pl_rd_q;

	// Control registers
	logic [BUDGET_W-1:0] budget_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [AW-1:0]       cur_q, raster_q, head_q, tail_q, clr_q;
	logic [CW-1:0]       count_q;
	logic [FC_W-1:0]     fc_q;
	logic [X_W-1:0]      x_q;
	logic [Y_W-1:0]      y_q;
	logic [ACC_W-1:0]    ay_q, ax_q;
	logic                have_q;
	rec_t                hold_q, rec_q, new_rec;
	logic                hold_v_q, rec_valid_q;

	logic                is_head, is_tail, interior, emit, out_free;
	logic                link_we, fs_we, pf_we, pf_wd;
	logic [AW-1:0]       nl_wa, nl_wd, pl_wa, pl_wd, fs_wa, pf_wa;
	logic [BYTE_W-1:0]   fs_wd;
	logic [AW-1:0]       row_full, col_full;

	assign is_head  = (cur_q == head_q);
	assign is_tail  = (cur_q == tail_q);
	assign interior = !is_head && !is_tail;
	assign emit     = cmd.emit_rec || cmd.emit_mark;
	assign out_free = !rec_valid_q || !rec_stall;

	// Memory write ports: unlink, push to front, clearing sweep, byte update
	assign link_we = (cmd.remove && interior) || (cmd.push && (count_q != '0));
	assign nl_wa   = cmd.push ? cur_q  : pl_rd_q;
	assign nl_wd   = cmd.push ? head_q : nl_rd_q;
	assign pl_wa   = cmd.push ? head_q : nl_rd_q;
	assign pl_wd   = cmd.push ? cur_q  : pl_rd_q;
	assign fs_we   = cmd.clr || cmd.write_byte;
	assign fs_wa   = cmd.clr ? clr_q : cur_q;
	assign fs_wd   = cmd.clr ? '0 : byte_q;
	assign pf_we   = cmd.clr || cmd.remove || cmd.push;
	assign pf_wa   = cmd.clr ? clr_q : cur_q;
	assign pf_wd   = cmd.push;

	always_ff @(posedge clk) begin
		if (fs_we) fs_mem[fs_wa] <= fs_wd;
		fs_rd_q <= fs_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (pf_we) pf_mem[pf_wa] <= pf_wd;
		pf_rd_q <= pf_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (link_we) nl_mem[nl_wa] <= nl_wd;
		nl_rd_q <= nl_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (link_we) pl_mem[pl_wa] <= pl_wd;
		pl_rd_q <= pl_mem[cur_q];
	end

	// List, counters and pass bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RST;
			byte_q   <= '0;
			cur_q    <= '0;
			raster_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			clr_q    <= '0;
			count_q  <= '0;
			fc_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			ay_q     <= '0;
			ax_q     <= '0;
			have_q   <= 1'b0;
		end else begin
			if (cfg_valid) budget_q <= cfg_data;
			if (cmd.latch_byte) byte_q <= pix_byte;
			if (cmd.clr) clr_q <= clr_q + 1'b1;

			case (cmd.cur_sel)
				CUR_RASTER: cur_q <= raster_q;
				CUR_HEAD:   cur_q <= head_q;
				CUR_TAIL:   cur_q <= tail_q;
				CUR_NEXT:   cur_q <= nl_rd_q;
				default:    cur_q <= cur_q;
			endcase

			// unlink the current entry
			if (cmd.remove) begin
				if (is_head) head_q <= nl_rd_q;
				if (is_tail) tail_q <= pl_rd_q;
				if (count_q != '0) count_q <= count_q - 1'b1;
			end

			// link the current entry in at the front
			if (cmd.push) begin
				head_q  <= cur_q;
				if (count_q == '0) tail_q <= cur_q;
				count_q <= count_q + 1'b1;
			end

			if (cmd.write_byte && (fc_q != FC_MAX)) fc_q <= fc_q + 1'b1;

			if (cmd.frame_end) begin
				fc_q     <= '0;
				raster_q <= '0;
			end else if (cmd.adv_raster) begin
				raster_q <= (raster_q == AW'(FRAME - 1)) ? '0 : raster_q + 1'b1;
			end

			// record spacing: entry y goes out when y*budget > changes*x
			if (cmd.p1_init) begin
				x_q    <= X_W'(1);
				y_q    <= Y_W'(1);
				ay_q   <= ACC_W'(budget_q);
				ax_q   <= ACC_W'(fc_q);
				have_q <= (count_q != '0);
			end
			if (cmd.p1_step) begin
				y_q  <= y_q + 1'b1;
				ay_q <= ay_q + ACC_W'(budget_q);
				if (is_tail) have_q <= 1'b0;
			end
			if (cmd.x_inc) begin
				x_q  <= x_q + 1'b1;
				ax_q <= ax_q + ACC_W'(fc_q);
			end
		end
	end

	// Build the next record
	assign row_full = AW'(cur_q / ROW_BYTES_DEF);
	assign col_full = AW'(cur_q % ROW_BYTES_DEF);
	always_comb begin
		new_rec.last = 1'b0;
		if (cmd.emit_mark) begin
			new_rec.row        = '0;
			new_rec.column     = '0;
			new_rec.byte_value = EOD_BYTE;
			new_rec.end_marker = 1'b1;
		end else begin
			new_rec.row        = ROW_W'(row_full);
			new_rec.column     = COL_W'(col_full);
			new_rec.byte_value = fs_rd_q;
			new_rec.end_marker = 1'b0;
		end
	end

	// Hold one record back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q    <= 1'b0;
			rec_valid_q <= 1'b0;
		end else begin
			if (cmd.flush || (emit && hold_v_q)) begin
				rec_valid_q <= 1'b1;
			end else if (!rec_stall) begin
				rec_valid_q <= 1'b0;
			end
			if (emit) begin
				hold_v_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			rec_q      <= hold_q;
			rec_q.last <= 1'b1;
		end else if (emit && hold_v_q) begin
			rec_q <= hold_q;
		end
		if (emit) hold_q <= new_rec;
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

	// Status to the controller
	always_comb begin
		stat.changed  = (byte_q != fs_rd_q);
		stat.pending  = pf_rd_q;
		stat.hit      = (ay_q > ax_q);
		stat.room     = (x_q <= X_W'(budget_q));
		stat.p1_more  = (y_q <= Y_W'(fc_q)) && stat.room && have_q;
		stat.p2_more  = stat.room && (count_q != '0);
		stat.out_free = out_free;
		stat.can_push = !hold_v_q || out_free;
		stat.hold_v   = hold_v_q;
		stat.clr_last = (clr_q == AW'(FRAME - 1));
	end

endmodule
`default_nettype wire

/* hw/rtl/frame_delta_budget_encoder.sv */
`default_nettype none
// Frame delta encoder with a per-frame record budget. Frame bytes arrive in raster
// order on the pix channel; each one is compared with the stored byte of the previous
// frame, and changed positions are kept in a linked list, newest first. An end-of-frame
// beat emits up to budget records (row, column, byte) on the rec channel, spread over
// this frame's changes and then topped up with the oldest pending positions, followed
// by an end marker if budget is left; last marks the final beat. The frame is 64 rows
// of 16 bytes. After reset the block clears its frame store and pending flags, one
// frame byte at a time, and stalls pix meanwhile. A frame byte is read, compared and,
// when it changed, linked in at the front, one step after the other, since the frame
// and link memories each have a single read port. An end-of-frame beat walks the
// list in a first pass (test, read, evaluate per entry), takes the oldest entries
// in a second pass, then emits the marker if budget is left and the final beat; a
// stalled rec channel holds it up. The user must write budget on the cfg channel only
// while the block is idle; the block itself does not enforce this.
module frame_delta_budget_encoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pix_valid,
	output logic                               pix_stall,
	input  wire fdbe_pkg::pix_t                pix,
	output logic                               rec_valid,
	input  wire logic                          rec_stall,
	output fdbe_pkg::rec_t                     rec,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [fdbe_pkg::BUDGET_W-1:0] cfg_budget
);
	import fdbe_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	fdbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.req_type  (pix.req_type),
		.pix_stall (pix_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fdbe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.pix_byte  (pix.pixel_byte),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_budget),
		.rec_stall (rec_stall),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

endmodule
`default_nettype wire

/* bench/frame_delta_budget_encoder_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module frame_delta_budget_encoder_tb;
	import fdbe_pkg::*;

	localparam int FRAME_N = ROWS_DEF * ROW_BYTES_DEF;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;
	logic rec_valid;
	logic rec_stall;
	rec_t rec;
	logic cfg_valid;
	logic cfg_ready;
	logic [BUDGET_W-1:0] cfg_budget;

	frame_delta_budget_encoder i_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.rec_valid(rec_valid), .rec_stall(rec_stall), .rec(rec),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_budget(cfg_budget)
	);

	// Predictor state: frame copy and pending list
	logic [7:0]  shadow_frame [FRAME_N];
	logic        shadow_pend [FRAME_N];
	logic [9:0]  nxt_ln [FRAME_N];
	logic [9:0]  prv_ln [FRAME_N];
	logic [9:0]  head_p, tail_p;
	int          pend_cnt;
	int          raster_p;
	int          changes_n;
	int          budget_r;

	rec_t expected_recs[$];
	int   errors, mismatches, beats_in, recs_out, frames_n;
	int   idle_pct;

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	function automatic void list_drop(input int p);
		if (p == head_p) head_p = nxt_ln[p];
		else nxt_ln[prv_ln[p]] = nxt_ln[p];
		if (p == tail_p) tail_p = prv_ln[p];
		else prv_ln[nxt_ln[p]] = prv_ln[p];
		if (pend_cnt > 0) pend_cnt--;
		shadow_pend[p] = 1'b0;
	endfunction

	function automatic void queue_rec(input int p);
		rec_t r;
		r.row = 6'(p / ROW_BYTES_DEF);
		r.column = 4'(p % ROW_BYTES_DEF);
		r.byte_value = shadow_frame[p];
		r.end_marker = 1'b0;
		r.last = 1'b0;
		expected_recs.push_back(r);
		list_drop(p);
	endfunction

	// Compute the records that one accepted beat causes
	function automatic void predict_beat(input pix_t b);
		int p, x, y, cur, nx, n0;
		bit have, at_end;
		rec_t r;
		if (b.req_type == REQ_BYTE) begin
			p = raster_p;
			if (b.pixel_byte != shadow_frame[p]) begin
				if (changes_n < 2047) changes_n++;
				shadow_frame[p] = b.pixel_byte;
				if (shadow_pend[p]) list_drop(p);
				if (pend_cnt == 0) begin
					head_p = 10'(p); tail_p = 10'(p);
				end else begin
					nxt_ln[p] = head_p; prv_ln[head_p] = 10'(p); head_p = 10'(p);
				end
				prv_ln[p] = 10'(p);
				pend_cnt++;
				shadow_pend[p] = 1'b1;
			end
			raster_p = (p + 1) % FRAME_N;
			return;
		end
		n0 = expected_recs.size();
		x = 1;
		have = pend_cnt > 0;
		cur = head_p;
		for (y = 1; y <= changes_n && x <= budget_r && have; y++) begin
			nx = nxt_ln[cur];
			at_end = (cur == tail_p);
			if (y * budget_r > changes_n * x) begin
				queue_rec(cur);
				x++;
			end
			if (at_end) have = 0;
			else cur = nx;
		end
		while (x <= budget_r && pend_cnt > 0) begin
			queue_rec(tail_p);
			x++;
		end
		if (x <= budget_r) begin
			r.row = '0; r.column = '0; r.byte_value = EOD_BYTE;
			r.end_marker = 1'b1; r.last = 1'b0;
			expected_recs.push_back(r);
		end
		if (expected_recs.size() > n0) expected_recs[$].last = 1'b1;
		changes_n = 0;
		raster_p = 0;
		frames_n++;
	endfunction

	// Receive side: random stall, compare each accepted beat
	always @(posedge clk) begin
		rec_t e;
		if (arst_n && rec_valid && !rec_stall) begin
			recs_out++;
			if (expected_recs.size() == 0) begin
				errors++;
				if (mismatches < 10) $display("unexpected record %p", rec);
				mismatches++;
			end else begin
				e = expected_recs.pop_front();
				if (rec !== e) begin
					errors++;
					if (mismatches < 10)
						$display("record mismatch: expected %p, got %p", e, rec);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		rec_stall <= ($urandom_range(99) < idle_pct);
	end

	task automatic send_beat(input logic rt, input logic [7:0] pb);
		while ($urandom_range(99) < idle_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		pix.req_type <= rt;
		pix.pixel_byte <= pb;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		predict_beat('{req_type: rt, pixel_byte: pb});
		beats_in++;
		@(negedge clk);
	endtask

	task automatic drain_then_pause();
		pix_valid <= 1'b0;
		while (expected_recs.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_budget(input int v);
		drain_then_pause();
		cfg_valid <= 1'b1;
		cfg_budget <= 6'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		budget_r = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Directed rows: type, byte, whether a typed result applies, that result
	typedef struct {
		logic       rt;
		logic [7:0] pb;
		bit         chk;
		rec_t       exp;
	} stim_row_t;

	localparam rec_t MARK_ONLY = '{row: '0, column: '0, byte_value: EOD_BYTE,
		end_marker: 1'b1, last: 1'b1};

	stim_row_t directed_rows[] = '{
		'{REQ_EOF, 8'h00, 1'b1, MARK_ONLY},
		'{REQ_BYTE, 8'hFF, 1'b0, '0}, '{REQ_BYTE, 8'h00, 1'b0, '0},
		'{REQ_BYTE, 8'hA5, 1'b0, '0}, '{REQ_BYTE, 8'h5A, 1'b0, '0},
		'{REQ_BYTE, 8'h01, 1'b0, '0}, '{REQ_EOF, 8'h00, 1'b0, '0},
		'{REQ_BYTE, 8'hFF, 1'b0, '0}, '{REQ_BYTE, 8'h80, 1'b0, '0},
		'{REQ_EOF, 8'h00, 1'b0, '0},
		'{REQ_EOF, 8'hFF, 1'b1, MARK_ONLY}
	};

	initial begin
		#20_000_000;
		$display("frame_delta_budget_encoder test failed");
		$finish;
	end

	initial begin
		int i, k, len;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		rec_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_budget = '0;
		idle_pct = 16;
		errors = 0; mismatches = 0; beats_in = 0; recs_out = 0; frames_n = 0;
		for (i = 0; i < FRAME_N; i++) begin
			shadow_frame[i] = '0; shadow_pend[i] = 1'b0;
			nxt_ln[i] = '0; prv_ln[i] = '0;
		end
		head_p = '0; tail_p = '0; pend_cnt = 0;
		raster_p = 0; changes_n = 0; budget_r = BUDGET_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed walk, first with reset budget, then budgets of one, zero and two
		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].rt, directed_rows[i].pb);
			if (directed_rows[i].chk) begin
				if (expected_recs.size() == 0 ||
					expected_recs[$] !== directed_rows[i].exp) begin
					errors++;
					if (mismatches < 10)
						$display("directed row %0d: expected %p not predicted",
							i, directed_rows[i].exp);
					mismatches++;
				end
			end
		end
		set_budget(1);
		send_beat(REQ_BYTE, 8'h3C); send_beat(REQ_BYTE, 8'hC3); send_beat(REQ_EOF, 8'h00);
		set_budget(0);
		send_beat(REQ_BYTE, 8'h11); send_beat(REQ_EOF, 8'h00);
		set_budget(2);
		send_beat(REQ_EOF, 8'h00);

		// Random frames; budget changes between phases
		while (beats_in < 410) begin
			if ($urandom_range(3) == 0) begin
				k = $urandom_range(4);
				set_budget(k == 0 ? 63 : k == 1 ? 1 : $urandom_range(63));
			end
			idle_pct = (frames_n % 7 == 3) ? 0 : 16;
			len = $urandom_range(40);
			for (k = 0; k < len; k++)
				send_beat(REQ_BYTE, ($urandom_range(2) == 0) ? 8'($urandom) :
					shadow_frame[raster_p]);
			send_beat(REQ_EOF, 8'($urandom));
		end
		drain_then_pause();

		$display("covered %0d input beats in %0d frames, %0d records checked",
			beats_in, frames_n, recs_out);
		if (errors == 0 && expected_recs.size() == 0) begin
			$display("frame_delta_budget_encoder test passed");
		end else begin
			$display("frame_delta_budget_encoder test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
